@@ src/whe_pkg.sv @@
// Shared types, constants and op codes for the weighted histogram engine.
package whe_pkg;

   localparam int MAX_BINS_DEFAULT = 256;
   localparam int CNT_W = 32;
   localparam int STORE_SUM_W = 48;
   localparam int OUT_SUM_W = 57;
   localparam int VAL_W = 32;
   localparam int IDX_W = 9;
   localparam int DIV_W = 41;

   typedef enum logic [2:0] {
      OP_FILL = 3'd0,
      OP_FIND = 3'd1,
      OP_READ = 3'd2,
      OP_INTEGRAL = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_LOOKUP,
      ST_READ_WAIT,
      ST_FILL_WRITE,
      ST_SUM_ADDR,
      ST_SUM_ACC,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      REG_LOW = 2'd0,
      REG_HIGH = 2'd1,
      REG_BINS = 2'd2
   } reg_type;

   // divider handshake between sequencer and divide unit
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

@@ src/whe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module whe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 258
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/whe_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module whe_divider
   import whe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] numer,
   input  logic [VAL_W:0]   denom,
   output logic [IDX_W-1:0] quotient,
   output div_ctl_type      ctl
);

   localparam int CNT_BITS = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [VAL_W+1:0]    rem_ff, rem_in;
   logic [VAL_W:0]      den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [VAL_W+1:0]    trial;

   // one shift and compare-subtract step per cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[VAL_W:0], quo_ff[DIV_W-1]};
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_BITS'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // quotient is below n, so the low bits carry it
   assign quotient = quo_ff[IDX_W-1:0];
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;

endmodule

@@ src/weighted_histogram_engine_core.sv @@
// Top level of the weighted histogram engine: sequencer, stores and ports.
//
// One item is handled at a time; req_ready is low while an item is at work
// or a result waits. Fill and find of an in-range value go through the
// one-bit-a-cycle divider (41 steps) that forms the bin index; out-of-range
// values and a value equal to high skip it. Read goes through the registered
// store ports. Integral walks from the lower to the upper bin, one bin a pass
// of the single accumulator. Clear sweeps all MAX_BINS + 2 entries of the
// stores; after reset the same sweep runs before the first item is
// accepted. The result sits in an output register until rsp_ready.
module weighted_histogram_engine_core
   import whe_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_op,
   input  logic signed [VAL_W-1:0]     req_value,
   input  logic signed [VAL_W-1:0]     req_weight,
   input  logic [IDX_W-1:0]            req_bin_select,
   input  logic [IDX_W-1:0]            req_end_bin,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [IDX_W-1:0]            rsp_bin_index,
   output logic [CNT_W-1:0]            rsp_entry_count,
   output logic signed [OUT_SUM_W-1:0] rsp_bin_sum,
   output logic                        rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [3:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int DEPTH = MAX_BINS + 2;
   localparam int AW = $clog2(DEPTH);
   localparam int NB_W = $clog2(MAX_BINS + 1);
   localparam logic signed [STORE_SUM_W-1:0] SUM_MAX = {1'b0, {(STORE_SUM_W-1){1'b1}}};
   localparam logic signed [STORE_SUM_W-1:0] SUM_MIN = {1'b1, {(STORE_SUM_W-1){1'b0}}};
   localparam logic signed [OUT_SUM_W-1:0] OUT_MAX = {1'b0, {(OUT_SUM_W-1){1'b1}}};
   localparam logic signed [OUT_SUM_W-1:0] OUT_MIN = {1'b1, {(OUT_SUM_W-1){1'b0}}};

   // configuration registers
   logic signed [VAL_W-1:0] low_ff, high_ff;
   logic [IDX_W-1:0]        bins_ff;
   logic                    csr_write;
   logic [1:0]              csr_index;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         high_ff <= 32'sd16777216;
         bins_ff <= 9'd256;
      end else if (csr_write) begin
         case (csr_index)
            REG_LOW: low_ff <= pwdata;
            REG_HIGH: high_ff <= pwdata;
            REG_BINS: bins_ff <= pwdata[IDX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LOW: prdata = low_ff;
         REG_HIGH: prdata = high_ff;
         REG_BINS: prdata = {23'd0, bins_ff};
         default: prdata = '0;
      endcase
   end

   // effective inner bin count, clamped to 1..MAX_BINS
   logic [NB_W-1:0] nbins;
   logic [12:0]     full;
   always_comb begin
      if (bins_ff == '0) begin
         nbins = NB_W'(1);
      end else if ({4'd0, bins_ff} > 13'(MAX_BINS)) begin
         nbins = NB_W'(MAX_BINS);
      end else begin
         nbins = NB_W'(bins_ff);
      end
      full = 13'(nbins) + 13'd2;
   end

   // latched item
   logic [2:0]              op_ff;
   logic signed [VAL_W-1:0] val_ff, wgt_ff;
   logic [IDX_W-1:0]        sel_ff, endb_ff;

   // sequencer state
   state_type   state_ff, state_in;
   logic [12:0] idx_ff, idx_in;
   logic [12:0] hi_ff, hi_in;
   logic signed [OUT_SUM_W-1:0] acc_ff, acc_in;

   // result register
   logic                        rv_ff, rv_in;
   logic [IDX_W-1:0]            ridx_ff, ridx_in;
   logic [CNT_W-1:0]            rcnt_ff, rcnt_in;
   logic signed [OUT_SUM_W-1:0] rsum_ff, rsum_in;
   logic                        rst_ff, rst_in;

   // divide unit
   logic             div_start;
   logic [DIV_W-1:0] div_num;
   logic [VAL_W:0]   div_den;
   logic [IDX_W-1:0] div_q;
   div_ctl_type      div_ctl;
   logic [VAL_W:0]   diff_x;

   assign diff_x = {val_ff[VAL_W-1], val_ff} - {low_ff[VAL_W-1], low_ff};
   assign div_den = {high_ff[VAL_W-1], high_ff} - {low_ff[VAL_W-1], low_ff};
   assign div_num = DIV_W'(diff_x[VAL_W-1:0]) * DIV_W'(nbins);

   whe_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_num), .denom(div_den), .quotient(div_q), .ctl(div_ctl)
   );

   // stores
   logic                   wr_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [CNT_W-1:0]       cnt_wdata, cnt_rdata;
   logic [STORE_SUM_W-1:0] sum_wdata, sum_rdata;

   whe_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_cnt (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(cnt_wdata),
      .rd_addr(rd_addr), .rd_data(cnt_rdata)
   );
   whe_ram #(.WIDTH(STORE_SUM_W), .DEPTH(DEPTH)) u_sum (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(sum_wdata),
      .rd_addr(rd_addr), .rd_data(sum_rdata)
   );

   // fill arithmetic on the bin read back
   logic [CNT_W-1:0]       cnt_next;
   logic signed [STORE_SUM_W:0] sum_wide;
   logic signed [STORE_SUM_W-1:0] sum_next;
   logic signed [OUT_SUM_W:0] acc_wide;
   logic signed [OUT_SUM_W-1:0] acc_next;

   always_comb begin
      cnt_next = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
      sum_wide = {sum_rdata[STORE_SUM_W-1], sum_rdata} + (STORE_SUM_W+1)'(wgt_ff);
      if (sum_wide > (STORE_SUM_W+1)'(SUM_MAX)) begin
         sum_next = SUM_MAX;
      end else if (sum_wide < $signed({SUM_MIN[STORE_SUM_W-1], SUM_MIN})) begin
         sum_next = SUM_MIN;
      end else begin
         sum_next = sum_wide[STORE_SUM_W-1:0];
      end
      acc_wide = {acc_ff[OUT_SUM_W-1], acc_ff}
         + (OUT_SUM_W+1)'($signed(sum_rdata));
      if (acc_wide > (OUT_SUM_W+1)'(OUT_MAX)) begin
         acc_next = OUT_MAX;
      end else if (acc_wide < $signed({OUT_MIN[OUT_SUM_W-1], OUT_MIN})) begin
         acc_next = OUT_MIN;
      end else begin
         acc_next = acc_wide[OUT_SUM_W-1:0];
      end
   end

   logic req_fire;
   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign req_fire = req_valid && req_ready;

   // capture the item; the op starts known so the reset sweep ends in idle
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_FILL;
      end else if (req_fire) begin
         op_ff <= req_op;
         val_ff <= req_value;
         wgt_ff <= req_weight;
         sel_ff <= req_bin_select;
         endb_ff <= req_end_bin;
      end
   end

   // sequencer: next state, store access and result
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hi_in = hi_ff;
      acc_in = acc_ff;
      rv_in = rv_ff;
      ridx_in = ridx_ff;
      rcnt_in = rcnt_ff;
      rsum_in = rsum_ff;
      rst_in = rst_ff;
      div_start = 1'b0;
      wr_en = 1'b0;
      wr_addr = AW'(idx_ff);
      rd_addr = AW'(idx_ff);
      cnt_wdata = '0;
      sum_wdata = '0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == 13'(DEPTH - 1)) begin
               idx_in = '0;
               state_in = (op_ff == OP_CLEAR) ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ridx_in = sel_ff;
            rcnt_in = '0;
            rsum_in = '0;
            rst_in = 1'b0;
            acc_in = '0;
            case (op_ff)
               OP_FILL, OP_FIND: begin
                  if (val_ff < low_ff) begin
                     idx_in = '0;
                     state_in = (op_ff == OP_FILL) ? ST_READ_WAIT : ST_DONE;
                     ridx_in = '0;
                  end else if (val_ff > high_ff) begin
                     idx_in = 13'(nbins) + 13'd1;
                     ridx_in = IDX_W'(13'(nbins) + 13'd1);
                     state_in = (op_ff == OP_FILL) ? ST_READ_WAIT : ST_DONE;
                  end else if (val_ff == high_ff) begin
                     idx_in = 13'(nbins);
                     ridx_in = IDX_W'(nbins);
                     state_in = (op_ff == OP_FILL) ? ST_READ_WAIT : ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in = ST_DIVIDE;
                  end
               end
               OP_READ: begin
                  if (13'(sel_ff) < full) begin
                     idx_in = 13'(sel_ff);
                     state_in = ST_READ_WAIT;
                  end else begin
                     rst_in = 1'b1;
                     state_in = ST_DONE;
                  end
               end
               OP_INTEGRAL: begin
                  if (13'(sel_ff) < full && 13'(endb_ff) < full) begin
                     idx_in = 13'((sel_ff < endb_ff) ? sel_ff : endb_ff);
                     hi_in = 13'((sel_ff < endb_ff) ? endb_ff : sel_ff);
                     state_in = ST_SUM_ADDR;
                  end else begin
                     rst_in = 1'b1;
                     state_in = ST_DONE;
                  end
               end
               OP_CLEAR: begin
                  ridx_in = '0;
                  idx_in = '0;
                  state_in = ST_CLEAR;
               end
               default: begin
                  ridx_in = '0;
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_ctl.done) begin
               idx_in = 13'(div_q) + 13'd1;
               ridx_in = IDX_W'(13'(div_q) + 13'd1);
               state_in = (op_ff == OP_FILL) ? ST_READ_WAIT : ST_DONE;
            end
         end
         ST_READ_WAIT: begin
            // address presented; data arrives next cycle
            state_in = (op_ff == OP_FILL) ? ST_FILL_WRITE : ST_SUM_ACC;
         end
         ST_FILL_WRITE: begin
            wr_en = 1'b1;
            cnt_wdata = cnt_next;
            sum_wdata = sum_next;
            rcnt_in = cnt_next;
            rsum_in = OUT_SUM_W'(sum_next);
            state_in = ST_DONE;
         end
         ST_SUM_ADDR: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            if (op_ff == OP_READ) begin
               rcnt_in = cnt_rdata;
               rsum_in = OUT_SUM_W'($signed(sum_rdata));
               state_in = ST_DONE;
            end else begin
               acc_in = acc_next;
               if (idx_ff == hi_ff) begin
                  rsum_in = acc_next;
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = ST_SUM_ADDR;
               end
            end
         end
         ST_DONE: begin
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rv_ff <= rv_in;
      end
      hi_ff <= hi_in;
      acc_ff <= acc_in;
      ridx_ff <= ridx_in;
      rcnt_ff <= rcnt_in;
      rsum_ff <= rsum_in;
      rst_ff <= rst_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_bin_index = ridx_ff;
   assign rsp_entry_count = rcnt_ff;
   assign rsp_bin_sum = rsum_ff;
   assign rsp_status = rst_ff;

   // an item is never taken while a result waits
   assert property (@(posedge clock) disable iff (reset) rv_ff |-> !req_ready)
      else $error("item accepted with result pending");
   // divider only runs in the divide state
   assert property (@(posedge clock) disable iff (reset)
      div_ctl.busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide");
   // integral walk stays inside the table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM_ACC |-> idx_ff < 13'(DEPTH))
      else $error("integral walk past table");

endmodule

@@ sim/histogram_checker.sv @@
// Checker for the weighted histogram engine: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module histogram_checker
   import whe_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [2:0]           req_op,
   input  logic signed [31:0]   req_value,
   input  logic signed [31:0]   req_weight,
   input  logic [8:0]           req_bin_select,
   input  logic [8:0]           req_end_bin,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [8:0]           rsp_bin_index,
   input  logic [31:0]          rsp_entry_count,
   input  logic signed [56:0]   rsp_bin_sum,
   input  logic                 rsp_status,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output int                   fail_count,
   output int                   pending_count
);
   localparam int TBL = MAX_BINS + 2;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam longint OUT_HI = 64'sh00FF_FFFF_FFFF_FFFF;
   localparam longint OUT_LO = -OUT_HI - 1;

   typedef struct {
      logic [8:0]  idx;
      logic [31:0] cnt;
      logic [56:0] sum;
      logic        st;
   } bin_result_type;

   longint         edge_lo, edge_hi;
   logic [8:0]     bin_reg;
   logic [31:0]    hit_counts [TBL];
   longint         weight_sums [TBL];
   bin_result_type expected_results [$];

   assign pending_count = expected_results.size();

   function automatic longint active_bins();
      if (bin_reg == 0) return 1;
      if (bin_reg > MAX_BINS) return MAX_BINS;
      return bin_reg;
   endfunction

   // map a sample onto its bin, underflow and overflow included
   function automatic longint bin_of(longint x);
      longint n;
      n = active_bins();
      if (x < edge_lo) return 0;
      if (x > edge_hi) return n + 1;
      if (x == edge_hi) return n;
      return ((x - edge_lo) * n) / (edge_hi - edge_lo) + 1;
   endfunction

   // apply one item to the shadow histogram and return its result
   function automatic bin_result_type apply_item(logic [2:0] op, longint x, longint w,
                                                 int sel, int eb);
      bin_result_type r;
      longint full, s, lo, hi;
      int i;
      r = '{default: '0};
      full = active_bins() + 2;
      s = 0;
      case (op)
         OP_FILL, OP_FIND: begin
            i = int'(bin_of(x));
            r.idx = i[8:0];
            if (op == OP_FILL) begin
               if (hit_counts[i] != 32'hFFFF_FFFF) hit_counts[i]++;
               s = weight_sums[i] + w;
               if (s > SUM_HI) s = SUM_HI;
               if (s < SUM_LO) s = SUM_LO;
               weight_sums[i] = s;
               r.cnt = hit_counts[i];
               r.sum = s[56:0];
            end
         end
         OP_READ: begin
            r.idx = sel[8:0];
            if (sel < full) begin
               r.cnt = hit_counts[sel];
               r.sum = weight_sums[sel][56:0];
            end else r.st = 1;
         end
         OP_INTEGRAL: begin
            r.idx = sel[8:0];
            if (sel < full && eb < full) begin
               lo = sel < eb ? sel : eb;
               hi = sel < eb ? eb : sel;
               for (longint k = lo; k <= hi; k++) begin
                  s += weight_sums[k];
                  if (s > OUT_HI) s = OUT_HI;
                  if (s < OUT_LO) s = OUT_LO;
               end
               r.sum = s[56:0];
            end else r.st = 1;
         end
         OP_CLEAR: begin
            foreach (hit_counts[k]) begin
               hit_counts[k] = 0;
               weight_sums[k] = 0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // track registers and items; compare results against the oldest expectation
   always @(posedge clock) begin
      bin_result_type e;
      if (reset) begin
         edge_lo <= 0;
         edge_hi <= 16777216;
         bin_reg <= 9'd256;
         foreach (hit_counts[k]) begin
            hit_counts[k] = 0;
            weight_sums[k] = 0;
         end
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               REG_LOW: edge_lo <= longint'(signed'(pwdata));
               REG_HIGH: edge_hi <= longint'(signed'(pwdata));
               REG_BINS: bin_reg <= pwdata[8:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_item(req_op, longint'(req_value),
               longint'(req_weight), int'(req_bin_select), int'(req_end_bin)));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no item outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_bin_index !== e.idx || rsp_entry_count !== e.cnt ||
                   rsp_bin_sum !== e.sum || rsp_status !== e.st) begin
                  if (rsp_bin_index !== e.idx)
                     $error("bin_index exp %0d got %0d", e.idx, rsp_bin_index);
                  if (rsp_entry_count !== e.cnt)
                     $error("entry_count exp %0d got %0d", e.cnt, rsp_entry_count);
                  if (rsp_bin_sum !== e.sum)
                     $error("bin_sum exp %h got %h", e.sum, rsp_bin_sum);
                  if (rsp_status !== e.st)
                     $error("status exp %0d got %0d", e.st, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

@@ sim/testbench.sv @@
// Stimulus and verdict for the weighted histogram engine.
`timescale 1ns / 100ps
module testbench
   import whe_pkg::*;
;

   localparam int WATCHDOG = 200000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [2:0] req_op;
   logic signed [31:0] req_value, req_weight;
   logic [8:0] req_bin_select, req_end_bin;
   logic [8:0] rsp_bin_index;
   logic [31:0] rsp_entry_count;
   logic signed [56:0] rsp_bin_sum;
   logic rsp_status;
   logic psel, penable, pwrite, pready;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   int fail_count, pending_count, idle_cycles;
   logic [31:0] cur_lo, cur_hi;
   bit stall_mode;

   weighted_histogram_engine_core u_top (.*);

   histogram_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // stall the result side at random while stall_mode is set, else never
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1;
      else if (stall_mode) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= 1;
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input reg_type r, input logic [31:0] d);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= {r, 2'b00}; pwdata <= d;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_item(input logic [2:0] op, input logic [31:0] x, input logic [31:0] w,
                            input logic [8:0] sel, input logic [8:0] eb);
      req_valid <= 1; req_op <= op; req_value <= x; req_weight <= w;
      req_bin_select <= sel; req_end_bin <= eb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_range(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [8:0] n);
      drain();
      cur_lo = lo; cur_hi = hi;
      write_reg(REG_LOW, lo);
      write_reg(REG_HIGH, hi);
      write_reg(REG_BINS, n);
   endtask

   // pick a sample near the range most of the time
   function automatic logic [31:0] pick_value();
      int c;
      logic [32:0] span;
      c = $urandom_range(0, 9);
      span = {1'b0, cur_hi - cur_lo} + 33'd1;
      if (c == 0) return $urandom;
      if (c == 1) return cur_lo;
      if (c == 2) return cur_hi;
      if (c == 3) return cur_lo - 1;
      if (c == 4) return cur_hi + 1;
      return cur_lo + 32'({1'b0, $urandom} % span);
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(input int count, input int nmax);
      int sent, burst;
      logic [2:0] op;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            case ($urandom_range(0, 19))
               0: op = OP_CLEAR;
               1: op = 3'($urandom_range(5, 7));
               2, 3, 4: op = OP_READ;
               5, 6, 7: op = OP_INTEGRAL;
               8, 9: op = OP_FIND;
               default: op = OP_FILL;
            endcase
            send_item(op, pick_value(), pick_weight(),
                      9'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 511 : nmax + 1)),
                      9'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 511 : nmax + 1)));
            sent++;
         end
         req_valid <= 0;
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   endtask

   initial begin
      reset = 1; req_valid = 0; req_op = 0; req_value = 0; req_weight = 0;
      req_bin_select = 0; req_end_bin = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      stall_mode = 0; cur_lo = 0; cur_hi = 32'd16777216;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: defaults, extremes, bad bins, ignored ops, clear
      send_item(OP_FILL, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
      send_item(OP_FILL, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_item(OP_FILL, 32'h0100_0000, 32'hFFFF_FFFF, 0, 0);
      send_item(OP_FILL, 32'h0, 32'h0001_0000, 0, 0);
      send_item(OP_FILL, 32'h00FF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_item(OP_FIND, 32'h0080_0000, 0, 0, 0);
      send_item(OP_READ, 0, 0, 9'd0, 0);
      send_item(OP_READ, 0, 0, 9'd257, 0);
      send_item(OP_READ, 0, 0, 9'd258, 0);
      send_item(OP_READ, 0, 0, 9'd511, 0);
      send_item(OP_INTEGRAL, 0, 0, 9'd257, 9'd0);
      send_item(OP_INTEGRAL, 0, 0, 9'd0, 9'd257);
      send_item(OP_INTEGRAL, 0, 0, 9'd5, 9'd300);
      send_item(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF, 9'h1FF);
      send_item(3'd7, 0, 0, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0, 0);
      send_item(OP_READ, 0, 0, 9'd257, 0);
      // add the largest weight to one bin several times over
      repeat (6) send_item(OP_FILL, 32'h0000_0100, 32'h7FFF_FFFF, 0, 0);

      // reversed edges, one bin, zero bins, oversize bin count
      set_range(32'h0001_0000, 32'hFFFF_0000, 9'd0);
      send_item(OP_FILL, 32'h0001_0000, 32'h1234, 0, 0);
      send_item(OP_FIND, 32'h0000_0000, 0, 0, 0);
      send_item(OP_READ, 0, 0, 9'd2, 0);
      set_range(32'h8000_0000, 32'h7FFF_FFFF, 9'd511);
      random_phase(150, 257);
      stall_mode = 1;
      set_range(32'hFFF0_0000, 32'h0010_0000, 9'd1);
      random_phase(150, 2);
      set_range(32'h0000_0000, 32'h0000_0005, 9'd7);
      random_phase(150, 8);
      stall_mode = 0;
      set_range(32'h8000_0000, 32'h8000_0001, 9'd256);
      random_phase(100, 257);
      stall_mode = 1;
      set_range(32'hFF00_0000, 32'h0300_0000, 9'd16);
      random_phase(200, 17);
      set_range(32'h0000_0000, 32'h0100_0000, 9'd256);
      random_phase(150, 257);

      drain();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

@@ files.f @@
src/whe_pkg.sv
src/whe_ram.sv
src/whe_divider.sv
src/weighted_histogram_engine_core.sv
sim/histogram_checker.sv
sim/testbench.sv
